### hdl/swpe_pkg.sv
// Shared types and codes for the stack with positional edit.
// Used by the interfaces, the sequencer and the top level; no dependencies.
`default_nettype none

package swpe_pkg;

	localparam int DEPTH_DEF       = 32;
	localparam int VALUE_WIDTH_DEF = 32;

	// Fixed field widths of the request and result channels
	localparam int REQ_W    = 3;
	localparam int POS_W    = 6;
	localparam int IN_W     = 32;
	localparam int OUT_W    = 32;
	localparam int STATUS_W = 2;
	localparam int WIDE_W   = 64;

	localparam logic [REQ_W-1:0] REQ_PUSH   = 3'd0;
	localparam logic [REQ_W-1:0] REQ_POP    = 3'd1;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd2;
	localparam logic [REQ_W-1:0] REQ_INSERT = 3'd3;
	localparam logic [REQ_W-1:0] REQ_DUMP   = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

	typedef struct packed {
		logic signed [OUT_W-1:0] data_out;
		logic [STATUS_W-1:0]     status;
		logic                    last;
	} res_t;

endpackage

`default_nettype wire

### hdl/swpe_if.sv
// Request and result channel interfaces with valid/ready handshake.
// Depends on swpe_pkg for field widths.
`default_nettype none

interface swpe_req_if;
	logic                              valid;
	logic                              ready;
	logic [swpe_pkg::REQ_W-1:0]        req_type;
	logic [swpe_pkg::POS_W-1:0]        position;
	logic signed [swpe_pkg::IN_W-1:0]  value;

	modport source (output valid, output req_type, output position, output value,
		input ready);
	modport sink (input valid, input req_type, input position, input value,
		output ready);
endinterface

interface swpe_res_if;
	logic                                valid;
	logic                                ready;
	logic signed [swpe_pkg::OUT_W-1:0]   data_out;
	logic [swpe_pkg::STATUS_W-1:0]       status;
	logic                                last;

	modport source (output valid, output data_out, output status, output last,
		input ready);
	modport sink (input valid, input data_out, input status, input last,
		output ready);
endinterface

`default_nettype wire

### hdl/swpe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module swpe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### hdl/swpe_seq.sv
// Request sequencer: decodes a transaction, walks the store one word per step
// through the RAM port and builds each result. Depends on swpe_pkg, swpe_if.
`default_nettype none

module swpe_seq #(
	parameter int DEPTH       = swpe_pkg::DEPTH_DEF,
	parameter int VALUE_WIDTH = swpe_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	swpe_req_if.sink                      req,
	output logic                          res_valid,
	input  wire logic                     res_ready,
	output swpe_pkg::res_t                res,
	output logic                          ram_we,
	output logic [$clog2(DEPTH)-1:0]      ram_waddr,
	output logic [VALUE_WIDTH-1:0]        ram_wdata,
	output logic [$clog2(DEPTH)-1:0]      ram_raddr,
	input  wire logic [VALUE_WIDTH-1:0]   ram_rdata
);

	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CMP_W  = (CNT_W > swpe_pkg::POS_W) ? CNT_W : swpe_pkg::POS_W;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_EXEC   = 4'd1;
	localparam logic [3:0] S_POP_LD = 4'd2;
	localparam logic [3:0] S_RMV_RD = 4'd3;
	localparam logic [3:0] S_RMV_WR = 4'd4;
	localparam logic [3:0] S_INS_RD = 4'd5;
	localparam logic [3:0] S_INS_WR = 4'd6;
	localparam logic [3:0] S_DMP_RD = 4'd7;
	localparam logic [3:0] S_DMP_LD = 4'd8;
	localparam logic [3:0] S_EMIT   = 4'd9;

	logic [3:0]                      state_q, state_d;
	logic [CNT_W-1:0]                count_q, count_d;
	logic [CNT_W-1:0]                idx_q, idx_d;
	logic [CNT_W-1:0]                base_q, base_d;
	logic [swpe_pkg::REQ_W-1:0]      req_q;
	logic [swpe_pkg::POS_W-1:0]      pos_q;
	logic [VALUE_WIDTH-1:0]          val_q;
	swpe_pkg::res_t                  res_q, res_d;

	logic [swpe_pkg::WIDE_W-1:0]     val_x;
	logic [swpe_pkg::WIDE_W-1:0]     rd_x;
	logic [CMP_W-1:0]                pos_x, cnt_x, diff_x;
	logic                            pos_ok, full, empty;
	logic [CNT_W-1:0]                idx_p1, idx_m1, cnt_m1;
	logic                            accept;

	assign accept = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);

	// Sign-extend the input word to the wide form, then keep the stored width
	assign val_x = {{(swpe_pkg::WIDE_W - swpe_pkg::IN_W){req.value[swpe_pkg::IN_W-1]}},
		req.value};
	assign rd_x  = swpe_pkg::WIDE_W'(ram_rdata);

	assign pos_x  = CMP_W'(pos_q);
	assign cnt_x  = CMP_W'(count_q);
	assign diff_x = cnt_x - pos_x;
	assign pos_ok = (pos_q != '0) && (pos_x <= cnt_x);
	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);
	assign idx_p1 = idx_q + CNT_W'(1);
	assign idx_m1 = idx_q - CNT_W'(1);
	assign cnt_m1 = count_q - CNT_W'(1);

	assign res       = res_q;
	assign res_valid = (state_q == S_EMIT);

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		base_d    = base_q;
		res_d     = res_q;
		ram_we    = 1'b0;
		ram_waddr = idx_q[ADDR_W-1:0];
		ram_wdata = ram_rdata;
		ram_raddr = idx_q[ADDR_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				res_d   = '{data_out: '0, status: swpe_pkg::ST_OK, last: 1'b1};
				state_d = S_EMIT;
				unique case (req_q)
					swpe_pkg::REQ_PUSH: begin
						if (full) begin
							res_d.status = swpe_pkg::ST_FULL;
						end else begin
							ram_we    = 1'b1;
							ram_waddr = count_q[ADDR_W-1:0];
							ram_wdata = val_q;
							count_d   = count_q + CNT_W'(1);
						end
					end
					swpe_pkg::REQ_POP: begin
						if (empty) begin
							res_d.status = swpe_pkg::ST_EMPTY;
						end else begin
							ram_raddr = cnt_m1[ADDR_W-1:0];
							count_d   = cnt_m1;
							state_d   = S_POP_LD;
						end
					end
					swpe_pkg::REQ_REMOVE: begin
						if (!pos_ok) begin
							res_d.status = swpe_pkg::ST_REJECT;
						end else begin
							idx_d   = CNT_W'(diff_x);
							state_d = S_RMV_RD;
						end
					end
					swpe_pkg::REQ_INSERT: begin
						if (!pos_ok) begin
							res_d.status = swpe_pkg::ST_REJECT;
						end else if (full) begin
							res_d.status = swpe_pkg::ST_FULL;
						end else begin
							// base is the slot just below the new word
							base_d  = CNT_W'(diff_x);
							idx_d   = count_q;
							state_d = S_INS_RD;
						end
					end
					swpe_pkg::REQ_DUMP: begin
						if (empty) begin
							res_d.status = swpe_pkg::ST_EMPTY;
						end else begin
							idx_d   = cnt_m1;
							state_d = S_DMP_RD;
						end
					end
					default: begin
					end
				endcase
			end
			S_POP_LD: begin
				res_d   = '{data_out: rd_x[swpe_pkg::OUT_W-1:0], status: swpe_pkg::ST_OK,
					last: 1'b1};
				state_d = S_EMIT;
			end
			S_RMV_RD: begin
				// Move the word above down into the hole, bottom to top
				if (idx_p1 < count_q) begin
					ram_raddr = idx_p1[ADDR_W-1:0];
					state_d   = S_RMV_WR;
				end else begin
					count_d = cnt_m1;
					state_d = S_EMIT;
				end
			end
			S_RMV_WR: begin
				ram_we  = 1'b1;
				idx_d   = idx_p1;
				state_d = S_RMV_RD;
			end
			S_INS_RD: begin
				// Open the slot by moving words up, top first
				if (idx_m1 != base_q) begin
					ram_raddr = idx_m1[ADDR_W-1:0];
					state_d   = S_INS_WR;
				end else begin
					ram_we    = 1'b1;
					ram_wdata = val_q;
					count_d   = count_q + CNT_W'(1);
					state_d   = S_EMIT;
				end
			end
			S_INS_WR: begin
				ram_we  = 1'b1;
				idx_d   = idx_m1;
				state_d = S_INS_RD;
			end
			S_DMP_RD: begin
				state_d = S_DMP_LD;
			end
			S_DMP_LD: begin
				res_d   = '{data_out: rd_x[swpe_pkg::OUT_W-1:0], status: swpe_pkg::ST_OK,
					last: (idx_q == '0)};
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (res_ready) begin
					if (req_q == swpe_pkg::REQ_DUMP && !res_q.last) begin
						idx_d   = idx_m1;
						state_d = S_DMP_RD;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q  <= idx_d;
		base_q <= base_d;
		res_q  <= res_d;
		if (accept) begin
			req_q <= req.req_type;
			pos_q <= req.position;
			val_q <= val_x[VALUE_WIDTH-1:0];
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("word count beyond store depth");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_EXEC))
		else $error("accepted transaction not decoded next cycle");

	// Push and the upward moves of insert may write one slot above the top word
	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (CNT_W'(ram_waddr) <= count_q))
		else $error("store write outside held words");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res_q)))
		else $error("pending result changed before hand-off");

endmodule

`default_nettype wire

### hdl/stack_with_positional_edit_core.sv
// Bounded LIFO stack with remove and insert at a position counted from the top,
// and a full dump. One request is worked at a time by a sequencer that moves
// words through a single-port-pair RAM, with a read state and a write state per
// moved word. Every request is accepted in idle and decoded in an execute
// state; a push or a rejected or no-op request then emits its result, a pop
// first loads the read word, and a dump reads and loads each word before
// emitting it, moving on to the next word once that result is taken.
// The output register takes a result whenever it is empty or being drained,
// and the request side is ready again the cycle after the last hand-off.
// Depends on swpe_pkg, swpe_if, swpe_ram, swpe_seq.
`default_nettype none

module stack_with_positional_edit_core #(
	parameter int DEPTH       = swpe_pkg::DEPTH_DEF,
	parameter int VALUE_WIDTH = swpe_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	swpe_req_if.sink  req,
	swpe_res_if.source rsp
);

	localparam int ADDR_W = $clog2(DEPTH);

	logic                   res_valid, res_ready;
	swpe_pkg::res_t         res;
	logic                   ram_we;
	logic [ADDR_W-1:0]      ram_waddr, ram_raddr;
	logic [VALUE_WIDTH-1:0] ram_wdata, ram_rdata;

	logic                   ovalid_q;
	swpe_pkg::res_t         obuf_q;

	swpe_seq #(
		.DEPTH       (DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	swpe_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Output register: take a new result when empty or being drained
	assign res_ready = !ovalid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (res_ready) begin
			ovalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			obuf_q <= res;
		end
	end

	assign rsp.valid    = ovalid_q;
	assign rsp.data_out = obuf_q.data_out;
	assign rsp.status   = obuf_q.status;
	assign rsp.last     = obuf_q.last;

endmodule

`default_nettype wire
